// ----- rtl/swf_pkg.sv -----
// Shared types and constants for the servo write frame builder.
package swf_pkg;

	localparam int FRAME_LEN = 13;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	// Frame byte positions
	localparam logic [IDX_W-1:0] FB_HDR0  = IDX_W'(0);
	localparam logic [IDX_W-1:0] FB_HDR1  = IDX_W'(1);
	localparam logic [IDX_W-1:0] FB_ID    = IDX_W'(2);
	localparam logic [IDX_W-1:0] FB_LEN   = IDX_W'(3);
	localparam logic [IDX_W-1:0] FB_INST  = IDX_W'(4);
	localparam logic [IDX_W-1:0] FB_ADDR  = IDX_W'(5);
	localparam logic [IDX_W-1:0] FB_POSL  = IDX_W'(6);
	localparam logic [IDX_W-1:0] FB_POSH  = IDX_W'(7);
	localparam logic [IDX_W-1:0] FB_TIMEL = IDX_W'(8);
	localparam logic [IDX_W-1:0] FB_TIMEH = IDX_W'(9);
	localparam logic [IDX_W-1:0] FB_SPDL  = IDX_W'(10);
	localparam logic [IDX_W-1:0] FB_SPDH  = IDX_W'(11);
	localparam logic [IDX_W-1:0] FB_CSUM  = IDX_W'(12);

	localparam logic [7:0] HDR_BYTE   = 8'hFF;
	localparam logic [7:0] LEN_BYTE   = 8'h09;
	localparam logic [7:0] INST_WRITE = 8'h03;
	localparam logic [7:0] ADDR_GOAL  = 8'h2A;
	localparam logic [7:0] CONST_SUM  = LEN_BYTE + INST_WRITE + ADDR_GOAL;

	localparam logic [8:0] ANGLE_MAX = 9'd360;
	// 4095 / 360 is exactly 91 / 8
	localparam logic [6:0] POS_MUL   = 7'd91;
	localparam int         POS_SHIFT = 3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] MOVE_TIME_RST  = 16'd500;
	localparam logic [15:0] MOVE_SPEED_RST = 16'd500;

	localparam logic CFG_MOVE_TIME  = 1'b0;
	localparam logic CFG_MOVE_SPEED = 1'b1;

	typedef struct packed {
		logic [7:0]  id;
		logic [11:0] pos;
		logic [7:0]  psum;   // id + constants + position bytes, mod 256
	} swf_cmd_t;

endpackage

// ----- rtl/swf_front.sv -----
// Front end: takes a command word, clamps and scales the angle, stages it for the queue.
module swf_front import swf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] servo_id,
	input  logic [8:0] angle_deg,
	input  logic       q_full,
	output logic       q_push,
	output swf_cmd_t   cmd
);

	logic        valid_s1;
	swf_cmd_t    cmd_s1;
	logic [8:0]  deg_c;
	logic [14:0] prod;
	logic [11:0] pos;
	logic        accept;

	assign deg_c = (angle_deg > ANGLE_MAX) ? ANGLE_MAX : angle_deg;
	assign prod  = 15'(deg_c) * 15'(POS_MUL);
	assign pos   = prod[POS_SHIFT +: 12];

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.id   <= servo_id;
			cmd_s1.pos  <= pos;
			cmd_s1.psum <= servo_id + CONST_SUM + pos[7:0] + {4'b0, pos[11:8]};
		end
	end

endmodule

// ----- rtl/swf_queue.sv -----
// Short command queue between front and back ends.
module swf_queue import swf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  swf_cmd_t  wr_cmd,
	input  logic      pop,
	output swf_cmd_t  rd_cmd,
	output logic      empty,
	output logic      full
);

	swf_cmd_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ----- rtl/swf_back.sv -----
// Back end: one byte per cycle into byte_q while queued and unstalled.
module swf_back import swf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  swf_cmd_t    cmd,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic [15:0] move_time,
	input  logic [15:0] move_speed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             load;
	logic [7:0]       csum;
	logic [7:0]       nxt_byte;

	assign load  = !q_empty && (!out_valid_q || !out_stall);
	assign q_pop = load && (idx_q == FB_CSUM);
	assign csum  = ~(cmd.psum + move_time[7:0] + move_time[15:8]
		+ move_speed[7:0] + move_speed[15:8]);

	always_comb begin
		unique case (idx_q)
			FB_HDR0:  nxt_byte = HDR_BYTE;
			FB_HDR1:  nxt_byte = HDR_BYTE;
			FB_ID:    nxt_byte = cmd.id;
			FB_LEN:   nxt_byte = LEN_BYTE;
			FB_INST:  nxt_byte = INST_WRITE;
			FB_ADDR:  nxt_byte = ADDR_GOAL;
			FB_POSL:  nxt_byte = cmd.pos[7:0];
			FB_POSH:  nxt_byte = {4'b0, cmd.pos[11:8]};
			FB_TIMEL: nxt_byte = move_time[7:0];
			FB_TIMEH: nxt_byte = move_time[15:8];
			FB_SPDL:  nxt_byte = move_speed[7:0];
			FB_SPDH:  nxt_byte = move_speed[15:8];
			FB_CSUM:  nxt_byte = csum;
			default:  nxt_byte = HDR_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= FB_HDR0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= (idx_q == FB_CSUM) ? FB_HDR0 : idx_q + IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nxt_byte;
			last_q <= (idx_q == FB_CSUM);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

endmodule

// ----- rtl/servo_write_packet_framer.sv -----
// Servo write frame builder: one command word in, 13 frame bytes out.
// Each command is registered in the front stage, then held in the queue; each frame byte is registered at the back end.
// One frame byte per cycle while a command is queued and out_stall is low; 13 bytes per command.
// A two-entry queue lets the front take the next command while a frame is going out.
// Reset clears all control state; move_time and move_speed reset to 500.
module servo_write_packet_framer import swf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  servo_id,
	input  logic [8:0]  angle_deg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] move_time_q;
	logic [15:0] move_speed_q;
	swf_cmd_t    f_cmd;
	swf_cmd_t    q_cmd;
	logic        q_push;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_time_q  <= MOVE_TIME_RST;
			move_speed_q <= MOVE_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOVE_TIME:  move_time_q  <= cfg_data;
				CFG_MOVE_SPEED: move_speed_q <= cfg_data;
				default:        move_time_q  <= move_time_q;
			endcase
		end
	end

	swf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.servo_id  (servo_id),
		.angle_deg (angle_deg),
		.q_full    (q_full),
		.q_push    (q_push),
		.cmd       (f_cmd)
	);

	swf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (f_cmd),
		.pop    (q_pop),
		.rd_cmd (q_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	swf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (q_cmd),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.move_time  (move_time_q),
		.move_speed (move_speed_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
